// File: rtl/per_node_drop_oldest_fifo_defines.svh
// Assertion macros used by the checker file of the per-node descriptor FIFO.
`ifndef PER_NODE_DROP_OLDEST_FIFO_DEFINES_SVH
`define PER_NODE_DROP_OLDEST_FIFO_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off while reset is high
`define PNDO_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while reset is high
`define PNDO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/pndo_pkg.sv
// Shared types and constants of the per-node drop-oldest descriptor FIFO.
package pndo_pkg;

   // Queue geometry
   localparam int NODES       = 16;
   localparam int QUEUE_DEPTH = 64;
   localparam int NODE_W      = $clog2(NODES);
   localparam int POS_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = POS_W + 1;
   localparam int SLOT_W      = NODE_W + POS_W;
   localparam int SLOTS       = NODES * QUEUE_DEPTH;

   // Field widths
   localparam int ADDR_W   = 32;
   localparam int PORT_W   = 16;
   localparam int HANDLE_W = 32;
   localparam int TIME_W   = 32;
   localparam int ENTRY_W  = ADDR_W + PORT_W + HANDLE_W + TIME_W;

   // Stream word widths
   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 120;

   // Limit register
   localparam int              LIMIT_W     = 7;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd50;

   // Bit positions in the result word
   localparam int RSP_OCC_LSB  = ENTRY_W;
   localparam int RSP_DROP_BIT = ENTRY_W + CNT_W;

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_PEEK  = 2'd1,
      CMD_POP   = 2'd2,
      CMD_QUERY = 2'd3
   } cmd_type;

endpackage

// File: rtl/pndo_ram.sv
// Generic simple dual-port RAM with registered read.
module pndo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/per_node_drop_oldest_fifo.sv
// Top level: per-node drop-oldest descriptor FIFO with stream ports.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------
//  req      | in        | req_tvalid/tready    | tuser command, tdata descriptor
//  rsp      | out       | rsp_tvalid/tready    | tuser found, tdata head/status
//  csr      | in        | csr_we               | queue limit, 7 bits
//
//  One word per cycle sustained while the result is taken. A word sits in the
//  input register, where head pointer, count and descriptor RAM port are
//  worked, then in the result register (RAM read data).
//  Synchronous active-high reset empties all queues and sets the limit to 50.
//  A stalled result holds the whole pipeline; the input register still takes
//  a word while empty.
module per_node_drop_oldest_fifo
   import pndo_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // config
   input  logic                  csr_we,
   input  logic [LIMIT_W-1:0]    csr_wdata,
   // request
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // node_id, dest_addr, dest_port,
                                             // packet_handle, arrival_time, pad
   input  logic [1:0]            req_tuser,  // command
   // response
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // out_dest_addr, out_dest_port,
                                             // out_packet_handle, out_time,
                                             // occupancy, dropped_oldest
   output logic                  rsp_tuser   // found
);

   // input register
   logic                req_valid_ff;
   cmd_type             cmd_ff;
   logic [NODE_W-1:0]   node_ff;
   logic [ENTRY_W-1:0]  entry_ff;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                found_ff, found_in;
   logic                peek_hit_ff, peek_hit_in;
   logic [CNT_W-1:0]    occ_ff, occ_in;
   logic                drop_ff, drop_in;

   // per-queue state
   logic [POS_W-1:0]    head_ff [NODES];
   logic [CNT_W-1:0]    count_ff [NODES];
   logic [POS_W-1:0]    head_in;
   logic [CNT_W-1:0]    count_in;

   logic [LIMIT_W-1:0]  limit_ff;

   // working signals
   logic                advance, work;
   logic                node_ok;
   logic [POS_W-1:0]    head_cur, head_inc;
   logic [CNT_W-1:0]    cnt_cur, cnt_keep, lim_eff;
   logic                full_drop;
   logic                ram_we, ram_re;
   logic [SLOT_W-1:0]   ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0]  ram_rdata;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign work       = req_valid_ff && advance;
   assign req_tready = !req_valid_ff || advance;

   // limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         cmd_ff   <= cmd_type'(req_tuser);
         node_ff  <= req_tdata[NODE_W-1:0];
         entry_ff <= req_tdata[NODE_W +: ENTRY_W];
      end
   end

   // queue update for the word in the input register
   always_comb begin
      node_ok   = (32'(node_ff) < NODES);
      head_cur  = head_ff[node_ff];
      cnt_cur   = count_ff[node_ff];
      head_inc  = head_cur + 1'b1;
      // zero acts as one, above depth acts as depth
      if (limit_ff == '0) begin
         lim_eff = CNT_W'(1);
      end else if (CNT_W'(limit_ff) > CNT_W'(QUEUE_DEPTH)) begin
         lim_eff = CNT_W'(QUEUE_DEPTH);
      end else begin
         lim_eff = CNT_W'(limit_ff);
      end
      full_drop = (cnt_cur >= lim_eff);
      cnt_keep  = full_drop ? cnt_cur - 1'b1 : cnt_cur;

      head_in     = head_cur;
      count_in    = cnt_cur;
      ram_we      = 1'b0;
      ram_waddr   = {node_ff, head_cur + cnt_keep[POS_W-1:0]};
      ram_raddr   = {node_ff, head_cur};
      found_in    = 1'b0;
      peek_hit_in = 1'b0;
      drop_in     = 1'b0;

      if (node_ok) begin
         unique case (cmd_ff)
            CMD_PUSH: begin
               ram_we   = 1'b1;
               drop_in  = full_drop;
               count_in = cnt_keep + 1'b1;
               if (full_drop) begin
                  head_in   = head_inc;
                  ram_waddr = {node_ff, head_inc + cnt_keep[POS_W-1:0]};
               end
            end
            CMD_PEEK: begin
               found_in    = (cnt_cur != '0);
               peek_hit_in = (cnt_cur != '0);
            end
            CMD_POP: begin
               found_in = (cnt_cur != '0);
               if (cnt_cur != '0) begin
                  head_in  = head_inc;
                  count_in = cnt_cur - 1'b1;
               end
            end
            CMD_QUERY: begin
               found_in = (cnt_cur != '0);
            end
            default: begin
               found_in = 1'b0;
            end
         endcase
      end
      occ_in       = node_ok ? count_in : '0;
      rsp_valid_in = req_valid_ff;
      ram_re       = work && peek_hit_in;
   end

   // head pointers and counts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NODES; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else if (work && node_ok) begin
         head_ff[node_ff]  <= head_in;
         count_ff[node_ff] <= count_in;
      end
   end

   // descriptor store
   pndo_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (work && ram_we),
      .wr_addr (ram_waddr),
      .wr_data (entry_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (work) begin
         found_ff    <= found_in;
         peek_hit_ff <= peek_hit_in;
         occ_ff      <= occ_in;
         drop_ff     <= drop_in;
      end
   end

   // data fields are zero unless a peek hit
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = found_ff;
   assign rsp_tdata  = {drop_ff, occ_ff, peek_hit_ff ? ram_rdata : {ENTRY_W{1'b0}}};

endmodule

// File: rtl/pndo_checker.sv
// Port-level checker for the per-node drop-oldest descriptor FIFO, bound to the top.
`include "per_node_drop_oldest_fifo_defines.svh"

module pndo_checker
   import pndo_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   // a stalled result word holds
   `PNDO_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result word changed under stall")

   // a drop comes only from a push, which never reports found
   `PNDO_ASSERT_NOW(a_found_no_drop, clock, reset, rsp_tvalid && rsp_tuser, !rsp_tdata[RSP_DROP_BIT], "found and drop together")

   // after a drop the queue still holds the new word
   `PNDO_ASSERT_NOW(a_drop_occ, clock, reset, rsp_tvalid && rsp_tdata[RSP_DROP_BIT], rsp_tdata[RSP_DROP_BIT-1:RSP_OCC_LSB] != '0, "drop with empty queue")

   // occupancy never exceeds the queue depth
   `PNDO_ASSERT_NOW(a_occ_max, clock, reset, rsp_tvalid, rsp_tdata[RSP_DROP_BIT-1:RSP_OCC_LSB] <= CNT_W'(QUEUE_DEPTH), "occupancy above depth")

   // descriptor fields are zero when nothing was found
   `PNDO_ASSERT_NOW(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[ENTRY_W-1:0] == '0, "data on a miss")

endmodule

bind per_node_drop_oldest_fifo pndo_checker u_checker (.*);

// File: tb/tb_per_node_drop_oldest_fifo.sv
// Self-checking bench for the per-node drop-oldest descriptor FIFO, predictor-based.
module tb_per_node_drop_oldest_fifo;
   import pndo_pkg::*;

   // Request word fields and response word fields
   typedef struct packed {
      cmd_type               cmd;
      logic [NODE_W-1:0]     node;
      logic [ADDR_W-1:0]     addr;
      logic [PORT_W-1:0]     port;
      logic [HANDLE_W-1:0]   handle;
      logic [TIME_W-1:0]     tick;
   } desc_req_type;

   typedef struct packed {
      logic                  found;
      logic [ADDR_W-1:0]     addr;
      logic [PORT_W-1:0]     port;
      logic [HANDLE_W-1:0]   handle;
      logic [TIME_W-1:0]     tick;
      logic [CNT_W-1:0]      occ;
      logic                  dropped;
   } desc_rsp_type;

   // Directed row: request plus, where obvious, the typed-in response
   typedef struct packed {
      desc_req_type          req;
      logic                  typed;
      desc_rsp_type          rsp;
   } op_row_type;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   localparam int N_PHASES  = 8;
   localparam int HOLD_LEN  = 300;
   localparam int DRAIN_CYC = 4;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [LIMIT_W-1:0]    csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [1:0]            req_tuser  = CMD_PUSH;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   // Shared control between stimulus and receiver
   idle_mode_type         idle_mode  = IDLE_NONE;
   logic                  hold_ask   = 1'b0;
   logic                  hold_taken = 1'b0;
   int                    hold_left  = 0;
   int                    mismatches = 0;

   // Predictor state
   logic [ADDR_W-1:0]     q_addr   [NODES][QUEUE_DEPTH];
   logic [PORT_W-1:0]     q_port   [NODES][QUEUE_DEPTH];
   logic [HANDLE_W-1:0]   q_handle [NODES][QUEUE_DEPTH];
   logic [TIME_W-1:0]     q_tick   [NODES][QUEUE_DEPTH];
   logic [POS_W-1:0]      q_head   [NODES];
   logic [CNT_W-1:0]      q_count  [NODES];
   logic [LIMIT_W-1:0]    q_limit;

   desc_rsp_type          pending_rsp [$];

   always #5 clock = ~clock;

   per_node_drop_oldest_fifo i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Apply one command to the predicted queues and return the response word
   function automatic desc_rsp_type predict_descriptor_op(input desc_req_type r);
      desc_rsp_type     res;
      int               lim;
      int               cnt;
      logic [POS_W-1:0] slot;
      res = '0;
      lim = q_limit;
      if (lim == 0) lim = 1;
      if (lim > QUEUE_DEPTH) lim = QUEUE_DEPTH;
      cnt = q_count[r.node];
      if (r.cmd == CMD_PUSH) begin
         // full (or over a lowered limit): drop only the single oldest
         if (cnt >= lim && cnt > 0) begin
            q_head[r.node] = q_head[r.node] + 1'b1;
            cnt = cnt - 1;
            res.dropped = 1'b1;
         end
         slot = q_head[r.node] + POS_W'(cnt);
         q_addr[r.node][slot]   = r.addr;
         q_port[r.node][slot]   = r.port;
         q_handle[r.node][slot] = r.handle;
         q_tick[r.node][slot]   = r.tick;
         cnt = cnt + 1;
         q_count[r.node] = CNT_W'(cnt);
      end else if (cnt > 0) begin
         res.found = 1'b1;
         if (r.cmd == CMD_PEEK) begin
            slot = q_head[r.node];
            res.addr   = q_addr[r.node][slot];
            res.port   = q_port[r.node][slot];
            res.handle = q_handle[r.node][slot];
            res.tick   = q_tick[r.node][slot];
         end else if (r.cmd == CMD_POP) begin
            q_head[r.node] = q_head[r.node] + 1'b1;
            cnt = cnt - 1;
            q_count[r.node] = CNT_W'(cnt);
         end
      end
      res.occ = CNT_W'(cnt);
      return res;
   endfunction

   // Offer one request word, idling first as the phase asks; predict on acceptance
   task automatic offer_descriptor_op(input desc_req_type it, input logic typed,
                                      input desc_rsp_type typed_rsp);
      int           gap_pct;
      desc_rsp_type pred;
      gap_pct = (idle_mode == IDLE_SENDER) ? 54 : (idle_mode == IDLE_BOTH) ? 21 : 0;
      while ($urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.cmd;
      req_tdata  <= {4'd0, it.tick, it.handle, it.port, it.addr, it.node};
      do @(posedge clock); while (!req_tready);
      pred = predict_descriptor_op(it);
      pending_rsp.push_back(typed ? typed_rsp : pred);
   endtask

   // Receiver: check each accepted response word, then pick next tready
   always @(posedge clock) begin
      desc_rsp_type got;
      desc_rsp_type want;
      int           stall_pct;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.found   = rsp_tuser;
         got.addr    = rsp_tdata[31:0];
         got.port    = rsp_tdata[47:32];
         got.handle  = rsp_tdata[79:48];
         got.tick    = rsp_tdata[111:80];
         got.occ     = rsp_tdata[RSP_OCC_LSB +: CNT_W];
         got.dropped = rsp_tdata[RSP_DROP_BIT];
         if (pending_rsp.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
               $display("unexpected response word: tuser %b tdata %h", rsp_tuser, rsp_tdata);
         end else begin
            want = pending_rsp.pop_front();
            if (got !== want) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10) begin
                  $display("mismatch exp: found %b addr %h port %h handle %h time %h occ %0d drop %b",
                           want.found, want.addr, want.port, want.handle, want.tick,
                           want.occ, want.dropped);
                  $display("         got: found %b addr %h port %h handle %h time %h occ %0d drop %b",
                           got.found, got.addr, got.port, got.handle, got.tick,
                           got.occ, got.dropped);
               end
            end
         end
      end
      // long hold-off, asked once, so the block backs up onto its input
      stall_pct = (idle_mode == IDLE_RECEIVER) ? 54 : (idle_mode == IDLE_BOTH) ? 21 : 0;
      if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_ask && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_LEN;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Fallback in case the handshake never completes
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   // Stimulus
   initial begin
      op_row_type    op_table [21];
      int            phase_items [N_PHASES];
      int            phase_push  [N_PHASES];
      int            phase_node  [N_PHASES];
      idle_mode_type phase_mode  [N_PHASES];
      int            phase_limit [N_PHASES];
      desc_req_type  it;
      int            ph;
      int            n;

      // directed table, queues empty, limit at reset value
      op_table = '{
         '{'{CMD_PEEK,  4'd0,  32'h0, 16'h0, 32'h0, 32'h0}, 1'b1,
           '{1'b0, 32'h0, 16'h0, 32'h0, 32'h0, 7'd0, 1'b0}},
         '{'{CMD_QUERY, 4'd0,  32'h0, 16'h0, 32'h0, 32'h0}, 1'b1,
           '{1'b0, 32'h0, 16'h0, 32'h0, 32'h0, 7'd0, 1'b0}},
         '{'{CMD_POP,   4'd0,  32'h0, 16'h0, 32'h0, 32'h0}, 1'b1,
           '{1'b0, 32'h0, 16'h0, 32'h0, 32'h0, 7'd0, 1'b0}},
         '{'{CMD_PUSH,  4'd0,  32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
           '{1'b0, 32'h0, 16'h0, 32'h0, 32'h0, 7'd1, 1'b0}},
         '{'{CMD_PEEK,  4'd0,  32'h0, 16'h0, 32'h0, 32'h0}, 1'b1,
           '{1'b1, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd1, 1'b0}},
         '{'{CMD_QUERY, 4'd0,  32'h0, 16'h0, 32'h0, 32'h0}, 1'b1,
           '{1'b1, 32'h0, 16'h0, 32'h0, 32'h0, 7'd1, 1'b0}},
         '{'{CMD_PUSH,  4'd15, 32'h0, 16'h0, 32'h0, 32'h0}, 1'b1,
           '{1'b0, 32'h0, 16'h0, 32'h0, 32'h0, 7'd1, 1'b0}},
         '{'{CMD_PEEK,  4'd15, 32'h0, 16'h0, 32'h0, 32'h0}, 1'b1,
           '{1'b1, 32'h0, 16'h0, 32'h0, 32'h0, 7'd1, 1'b0}},
         '{'{CMD_PUSH,  4'd0,  32'h0A00_0001, 16'd80, 32'h0000_1234, 32'd1000}, 1'b0, '0},
         '{'{CMD_POP,   4'd0,  32'h0, 16'h0, 32'h0, 32'h0}, 1'b1,
           '{1'b1, 32'h0, 16'h0, 32'h0, 32'h0, 7'd1, 1'b0}},
         '{'{CMD_PEEK,  4'd0,  32'h0, 16'h0, 32'h0, 32'h0}, 1'b0, '0},
         '{'{CMD_POP,   4'd0,  32'h0, 16'h0, 32'h0, 32'h0}, 1'b1,
           '{1'b1, 32'h0, 16'h0, 32'h0, 32'h0, 7'd0, 1'b0}},
         '{'{CMD_POP,   4'd0,  32'h0, 16'h0, 32'h0, 32'h0}, 1'b1,
           '{1'b0, 32'h0, 16'h0, 32'h0, 32'h0, 7'd0, 1'b0}},
         '{'{CMD_PUSH,  4'd15, 32'hC0A8_0001, 16'hFFFF, 32'h0, 32'hFFFF_FFFF}, 1'b0, '0},
         '{'{CMD_QUERY, 4'd15, 32'h0, 16'h0, 32'h0, 32'h0}, 1'b0, '0},
         '{'{CMD_POP,   4'd15, 32'h0, 16'h0, 32'h0, 32'h0}, 1'b0, '0},
         '{'{CMD_PEEK,  4'd15, 32'h0, 16'h0, 32'h0, 32'h0}, 1'b0, '0},
         '{'{CMD_POP,   4'd15, 32'h0, 16'h0, 32'h0, 32'h0}, 1'b0, '0},
         '{'{CMD_PEEK,  4'd15, 32'h0, 16'h0, 32'h0, 32'h0}, 1'b1,
           '{1'b0, 32'h0, 16'h0, 32'h0, 32'h0, 7'd0, 1'b0}},
         '{'{CMD_PUSH,  4'd5,  32'h8000_0000, 16'h8000, 32'h8000_0000, 32'h8000_0000},
           1'b0, '0},
         '{'{CMD_PEEK,  4'd5,  32'h0, 16'h0, 32'h0, 32'h0}, 1'b0, '0}
      };

      // phases: limit zero, limit one, over depth with a long hold-off,
      // full depth to fill queues, then a lowered limit, then mixed settings
      phase_limit = '{0, 1, 127, 64, 3, $urandom_range(1, 127), 50, $urandom_range(2, 10)};
      phase_items = '{150, 150, 250, 300, 200, 200, 200, 200};
      phase_push  = '{50, 50, 65, 70, 40, 50, 55, 50};
      phase_node  = '{3, 15, 3, 1, 1, 15, 7, 15};
      phase_mode  = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                      IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};

      // predictor reset state
      for (n = 0; n < NODES; n++) begin
         q_head[n]  = '0;
         q_count[n] = '0;
      end
      q_limit = LIMIT_RESET;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part
      foreach (op_table[i])
         offer_descriptor_op(op_table[i].req, op_table[i].typed, op_table[i].rsp);
      req_tvalid <= 1'b0;

      // random phases, limit written with the block drained
      for (ph = 0; ph < N_PHASES; ph++) begin
         while (pending_rsp.size() != 0) @(posedge clock);
         repeat (DRAIN_CYC) @(posedge clock);
         csr_we    <= 1'b1;
         csr_wdata <= LIMIT_W'(phase_limit[ph]);
         @(posedge clock);
         q_limit = LIMIT_W'(phase_limit[ph]);
         csr_we    <= 1'b0;
         idle_mode <= phase_mode[ph];
         if (ph == 2) hold_ask <= 1'b1;
         @(posedge clock);
         for (n = 0; n < phase_items[ph]; n++) begin
            if ($urandom_range(0, 99) < phase_push[ph]) begin
               it.cmd = CMD_PUSH;
            end else begin
               case ($urandom_range(0, 2))
                  0: it.cmd = CMD_PEEK;
                  1: it.cmd = CMD_POP;
                  default: it.cmd = CMD_QUERY;
               endcase
            end
            // mostly a narrow node set so queues get deep; now and then any node
            if ($urandom_range(0, 9) == 0)
               it.node = NODE_W'($urandom_range(0, NODES - 1));
            else
               it.node = NODE_W'($urandom_range(0, phase_node[ph]));
            it.addr   = $urandom;
            it.port   = PORT_W'($urandom);
            it.handle = $urandom;
            it.tick   = $urandom;
            offer_descriptor_op(it, 1'b0, '0);
         end
         req_tvalid <= 1'b0;
      end

      // drain, then idle on to catch stray words
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/pndo_pkg.sv
rtl/pndo_ram.sv
rtl/per_node_drop_oldest_fifo.sv
rtl/pndo_checker.sv
tb/tb_per_node_drop_oldest_fifo.sv
